// ===== hdl/npts_pkg.sv =====
// Shared types, codes and sizes for the nearest pending tile selector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package npts_pkg;
   localparam int MaxTiles = 64;
   localparam int TileIdxW = $clog2(MaxTiles);
   localparam int CountW   = $clog2(MaxTiles + 1);
   localparam int CoordW   = 24;
   localparam int SqW      = 2 * CoordW;
   localparam int DistW    = 50;
   localparam int RadW     = 23;
   localparam int Rad2W    = 2 * RadW;

   localparam logic [2:0] OpClear  = 3'd0;
   localparam logic [2:0] OpAppend = 3'd1;
   localparam logic [2:0] OpMark   = 3'd2;
   localparam logic [2:0] OpNear   = 3'd3;
   localparam logic [2:0] OpCount  = 3'd4;
   localparam logic [2:0] OpEvict  = 3'd5;

   localparam logic [1:0] StOk      = 2'd0;
   localparam logic [1:0] StNone    = 2'd1;
   localparam logic [1:0] StIgnored = 2'd2;

   localparam logic [1:0] TsCoarse  = 2'd0;
   localparam logic [1:0] TsFull    = 2'd2;
   localparam logic [1:0] TsInvalid = 2'd3;

   localparam logic [15:0] TileSizeReset = 16'd1024;

   typedef struct packed {
      logic [2:0]               operation;
      logic [5:0]               tile_index;
      logic [1:0]               new_state;
      logic                     has_instance;
      logic signed [CoordW-1:0] origin_x;
      logic signed [CoordW-1:0] origin_y;
      logic signed [CoordW-1:0] origin_z;
      logic signed [CoordW-1:0] focus_x;
      logic signed [CoordW-1:0] focus_y;
      logic signed [CoordW-1:0] focus_z;
      logic [RadW-1:0]          radius;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [5:0]       result_index;
      logic [6:0]       full_tiles;
      logic [DistW-1:0] distance_squared;
      logic             last;
   } rsp_type;

   // Queue entry: request with the append center already worked out.
   typedef struct packed {
      logic [2:0]               operation;
      logic [5:0]               tile_index;
      logic [1:0]               new_state;
      logic signed [CoordW-1:0] center_x;
      logic signed [CoordW-1:0] center_y;
      logic signed [CoordW-1:0] center_z;
      logic signed [CoordW-1:0] focus_x;
      logic signed [CoordW-1:0] focus_y;
      logic signed [CoordW-1:0] focus_z;
      logic [RadW-1:0]          radius;
   } cmd_type;
endpackage
`default_nettype wire

// ===== hdl/npts_front.sv =====
// Front end: tile size register, append center math and a two-beat queue.
// Depends on npts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module npts_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire npts_pkg::req_type req_data,
   input  wire logic             csr_wr_en,
   input  wire logic [15:0]      csr_wr_data,
   output logic                  cmd_valid,
   output npts_pkg::cmd_type     cmd_data,
   input  wire logic             cmd_pop
);
   import npts_pkg::*;

   logic [15:0]          tile_edge_ff;
   cmd_type              q_ff [2];
   logic                 wr_ptr_ff, rd_ptr_ff;
   logic [1:0]           cnt_ff, cnt_in;
   logic                 accept;
   logic [CoordW:0]      half, sum_x, sum_z;
   logic [CoordW-1:0]    cen_x, cen_z;
   cmd_type              entry;

   assign req_stall = (cnt_ff == 2'd2);
   assign accept    = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data  = q_ff[rd_ptr_ff];

   // Only positive overflow is possible since half a tile is never negative.
   always_comb begin
      half  = (CoordW+1)'(tile_edge_ff[15:1]);
      sum_x = {req_data.origin_x[CoordW-1], req_data.origin_x} + half;
      sum_z = {req_data.origin_z[CoordW-1], req_data.origin_z} + half;
      cen_x = (sum_x[CoordW] != sum_x[CoordW-1]) ? {1'b0, {(CoordW-1){1'b1}}}
                                                 : sum_x[CoordW-1:0];
      cen_z = (sum_z[CoordW] != sum_z[CoordW-1]) ? {1'b0, {(CoordW-1){1'b1}}}
                                                 : sum_z[CoordW-1:0];
      entry.operation  = req_data.operation;
      entry.tile_index = req_data.tile_index;
      entry.new_state  = req_data.new_state;
      entry.center_x   = req_data.has_instance ? cen_x : '0;
      entry.center_y   = req_data.has_instance ? req_data.origin_y : '0;
      entry.center_z   = req_data.has_instance ? cen_z : '0;
      entry.focus_x    = req_data.focus_x;
      entry.focus_y    = req_data.focus_y;
      entry.focus_z    = req_data.focus_z;
      entry.radius     = req_data.radius;
      cnt_in = cnt_ff + {1'b0, accept} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_edge_ff <= TileSizeReset;
         wr_ptr_ff    <= 1'b0;
         rd_ptr_ff    <= 1'b0;
         cnt_ff       <= 2'd0;
      end else begin
         if (csr_wr_en) tile_edge_ff <= csr_wr_data;
         if (accept) wr_ptr_ff <= !wr_ptr_ff;
         if (cmd_pop) rd_ptr_ff <= !rd_ptr_ff;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) q_ff[wr_ptr_ff] <= entry;
   end
endmodule
`default_nettype wire

// ===== hdl/npts_back.sv =====
// Back end: tile tables, distance scan pipeline, sequencer and result register.
// Depends on npts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module npts_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  wire npts_pkg::cmd_type cmd_data,
   output logic                   cmd_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output npts_pkg::rsp_type      rsp_data
);
   import npts_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic signed [CoordW-1:0] mem_cx [MaxTiles];
   logic signed [CoordW-1:0] mem_cy [MaxTiles];
   logic signed [CoordW-1:0] mem_cz [MaxTiles];
   logic [1:0]               mem_st [MaxTiles];
   logic                     we_all, we_st;
   logic [TileIdxW-1:0]      wa;

   logic [CountW-1:0]  count_ff, count_in, addr_ff, addr_in;
   logic [2:0]         op_ff, op_in;
   logic signed [CoordW-1:0] fx_ff, fy_ff, fz_ff;
   logic [Rad2W-1:0]   r2_ff;
   logic               latch;

   // scan pipeline
   logic               issue;
   logic               s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff;
   logic [TileIdxW-1:0] s1_idx_ff, s2_idx_ff, s3_idx_ff, s4_idx_ff;
   logic [1:0]         s1_st_ff, s2_st_ff, s3_st_ff, s4_st_ff;
   logic signed [CoordW-1:0] s1_cx_ff, s1_cy_ff, s1_cz_ff;
   logic [CoordW-1:0]  s2_ax_ff, s2_ay_ff, s2_az_ff;
   logic [SqW-1:0]     s3_qx_ff, s3_qy_ff, s3_qz_ff;
   logic [DistW-1:0]   s4_d_ff;
   logic [CoordW:0]    dx, dy, dz;

   // accumulators
   logic               best_found_ff, best_found_in;
   logic [DistW-1:0]   best_d_ff, best_d_in;
   logic [TileIdxW-1:0] best_idx_ff, best_idx_in;
   logic [CountW-1:0]  full_n_ff, full_n_in;
   logic               prev_have_ff, prev_have_in;
   logic [DistW-1:0]   prev_d_ff, prev_d_in;
   logic [TileIdxW-1:0] prev_idx_ff, prev_idx_in;
   logic               held_ff, held_in;
   logic [DistW-1:0]   held_d_ff, held_d_in;
   logic [TileIdxW-1:0] held_idx_ff, held_idx_in;
   logic               after_prev, take;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, emit_data;
   logic               emit, out_free, pipe_busy;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pipe_busy = s1_v_ff || s2_v_ff || s3_v_ff || s4_v_ff;
   assign issue     = (state_ff == ST_SCAN) && (addr_ff < count_ff);

   function automatic logic [CoordW-1:0] absdiff(input logic [CoordW:0] d);
      logic [CoordW:0] m;
      m = d[CoordW] ? (~d + (CoordW+1)'(1)) : d;
      return m[CoordW-1:0];
   endfunction

   always_comb begin
      dx = {fx_ff[CoordW-1], fx_ff} - {s1_cx_ff[CoordW-1], s1_cx_ff};
      dy = {fy_ff[CoordW-1], fy_ff} - {s1_cy_ff[CoordW-1], s1_cy_ff};
      dz = {fz_ff[CoordW-1], fz_ff} - {s1_cz_ff[CoordW-1], s1_cz_ff};
   end

   // candidate selection at the tail of the pipe
   always_comb begin
      after_prev = !prev_have_ff || (s4_d_ff < prev_d_ff) ||
                   ((s4_d_ff == prev_d_ff) && (s4_idx_ff > prev_idx_ff));
      take = 1'b0;
      if (s4_v_ff) begin
         priority if (op_ff == OpNear)
            take = (s4_st_ff == TsCoarse) && (!best_found_ff || s4_d_ff < best_d_ff);
         else if (op_ff == OpEvict)
            take = (s4_st_ff == TsFull) && (s4_d_ff > DistW'(r2_ff)) && after_prev &&
                   (!best_found_ff || s4_d_ff > best_d_ff);
         else
            take = 1'b0;
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      addr_in       = addr_ff;
      op_in         = op_ff;
      latch         = 1'b0;
      cmd_pop       = 1'b0;
      we_all        = 1'b0;
      we_st         = 1'b0;
      wa            = count_ff[TileIdxW-1:0];
      emit          = 1'b0;
      emit_data     = '0;
      emit_data.last = 1'b1;
      best_found_in = best_found_ff || take;
      best_d_in     = take ? s4_d_ff : best_d_ff;
      best_idx_in   = take ? s4_idx_ff : best_idx_ff;
      full_n_in     = full_n_ff + CountW'(s4_v_ff && (s4_st_ff == TsFull));
      prev_have_in  = prev_have_ff;
      prev_d_in     = prev_d_ff;
      prev_idx_in   = prev_idx_ff;
      held_in       = held_ff;
      held_d_in     = held_d_ff;
      held_idx_in   = held_idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd_data.operation)
                  OpClear: begin
                     if (out_free) begin
                        cmd_pop  = 1'b1;
                        emit     = 1'b1;
                        count_in = '0;
                     end
                  end
                  OpAppend: begin
                     if (out_free) begin
                        cmd_pop = 1'b1;
                        emit    = 1'b1;
                        if (count_ff >= CountW'(MaxTiles)) begin
                           emit_data.status = StIgnored;
                        end else begin
                           we_all = 1'b1;
                           emit_data.result_index = 6'(count_ff);
                           count_in = count_ff + CountW'(1);
                        end
                     end
                  end
                  OpMark: begin
                     if (out_free) begin
                        cmd_pop = 1'b1;
                        emit    = 1'b1;
                        if (7'(cmd_data.tile_index) >= 7'(count_ff) ||
                            cmd_data.new_state == TsInvalid) begin
                           emit_data.status = StIgnored;
                        end else begin
                           we_st = 1'b1;
                           wa    = cmd_data.tile_index[TileIdxW-1:0];
                           emit_data.result_index = cmd_data.tile_index;
                        end
                     end
                  end
                  OpNear, OpCount, OpEvict: begin
                     cmd_pop       = 1'b1;
                     latch         = 1'b1;
                     op_in         = cmd_data.operation;
                     addr_in       = '0;
                     best_found_in = 1'b0;
                     full_n_in     = '0;
                     prev_have_in  = 1'b0;
                     held_in       = 1'b0;
                     state_in      = ST_SCAN;
                  end
                  default: begin
                     if (out_free) begin
                        cmd_pop = 1'b1;
                        emit    = 1'b1;
                        emit_data.status = StIgnored;
                     end
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issue) addr_in = addr_ff + CountW'(1);
            else state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!pipe_busy) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            priority if (op_ff == OpCount) begin
               if (out_free) begin
                  emit = 1'b1;
                  emit_data.full_tiles = 7'(full_n_ff);
                  state_in = ST_IDLE;
               end
            end else if (op_ff == OpNear) begin
               if (out_free) begin
                  emit = 1'b1;
                  if (best_found_ff) begin
                     emit_data.result_index     = 6'(best_idx_ff);
                     emit_data.distance_squared = best_d_ff;
                  end else begin
                     emit_data.status = StNone;
                  end
                  state_in = ST_IDLE;
               end
            end else if (best_found_ff) begin
               // another candidate: release the held one, then scan again
               if (out_free || !held_ff) begin
                  emit = held_ff;
                  emit_data.result_index     = 6'(held_idx_ff);
                  emit_data.distance_squared = held_d_ff;
                  emit_data.last             = 1'b0;
                  held_in       = 1'b1;
                  held_d_in     = best_d_ff;
                  held_idx_in   = best_idx_ff;
                  prev_have_in  = 1'b1;
                  prev_d_in     = best_d_ff;
                  prev_idx_in   = best_idx_ff;
                  best_found_in = 1'b0;
                  addr_in       = '0;
                  state_in      = ST_SCAN;
               end
            end else begin
               if (out_free) begin
                  emit = 1'b1;
                  if (held_ff) begin
                     emit_data.result_index     = 6'(held_idx_ff);
                     emit_data.distance_squared = held_d_ff;
                  end else begin
                     emit_data.status = StNone;
                  end
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (emit) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         s1_v_ff       <= 1'b0;
         s2_v_ff       <= 1'b0;
         s3_v_ff       <= 1'b0;
         s4_v_ff       <= 1'b0;
         best_found_ff <= 1'b0;
         prev_have_ff  <= 1'b0;
         held_ff       <= 1'b0;
         full_n_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         s1_v_ff       <= issue;
         s2_v_ff       <= s1_v_ff;
         s3_v_ff       <= s2_v_ff;
         s4_v_ff       <= s3_v_ff;
         best_found_ff <= best_found_in;
         prev_have_ff  <= prev_have_in;
         held_ff       <= held_in;
         full_n_ff     <= full_n_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      op_ff       <= op_in;
      best_d_ff   <= best_d_in;
      best_idx_ff <= best_idx_in;
      prev_d_ff   <= prev_d_in;
      prev_idx_ff <= prev_idx_in;
      held_d_ff   <= held_d_in;
      held_idx_ff <= held_idx_in;
      if (latch) begin
         fx_ff <= cmd_data.focus_x;
         fy_ff <= cmd_data.focus_y;
         fz_ff <= cmd_data.focus_z;
         r2_ff <= cmd_data.radius * cmd_data.radius;
      end
      if (emit) rsp_data_ff <= emit_data;
      // distance pipeline
      s2_idx_ff <= s1_idx_ff;
      s2_st_ff  <= s1_st_ff;
      s2_ax_ff  <= absdiff(dx);
      s2_ay_ff  <= absdiff(dy);
      s2_az_ff  <= absdiff(dz);
      s3_idx_ff <= s2_idx_ff;
      s3_st_ff  <= s2_st_ff;
      s3_qx_ff  <= s2_ax_ff * s2_ax_ff;
      s3_qy_ff  <= s2_ay_ff * s2_ay_ff;
      s3_qz_ff  <= s2_az_ff * s2_az_ff;
      s4_idx_ff <= s3_idx_ff;
      s4_st_ff  <= s3_st_ff;
      s4_d_ff   <= DistW'(s3_qx_ff) + DistW'(s3_qy_ff) + DistW'(s3_qz_ff);
   end

   // tile tables
   always_ff @(posedge clock) begin
      if (we_all) begin
         mem_cx[wa] <= cmd_data.center_x;
         mem_cy[wa] <= cmd_data.center_y;
         mem_cz[wa] <= cmd_data.center_z;
      end
      if (we_all || we_st) mem_st[wa] <= we_all ? TsCoarse : cmd_data.new_state;
      if (issue) begin
         s1_cx_ff  <= mem_cx[addr_ff[TileIdxW-1:0]];
         s1_cy_ff  <= mem_cy[addr_ff[TileIdxW-1:0]];
         s1_cz_ff  <= mem_cz[addr_ff[TileIdxW-1:0]];
         s1_st_ff  <= mem_st[addr_ff[TileIdxW-1:0]];
         s1_idx_ff <= addr_ff[TileIdxW-1:0];
      end
   end
endmodule
`default_nettype wire

// ===== hdl/nearest_pending_tile_selector_unit.sv =====
// Top level of the nearest pending tile selector: front queue plus back engine.
// Depends on npts_pkg, npts_front and npts_back.
//
// Usage:
//   req_* carries one command beat (clear, append, mark, nearest, count, evict);
//   a beat moves when req_valid is high and req_stall is low. rsp_* returns
//   result beats the same way; rsp_data.last marks the final beat of a command.
//   csr_wr_en/csr_wr_data write the tile edge length; users write only while the block is idle, unchecked.
// Timing:
//   A two-beat queue sits in front, so commands are taken while the engine is
//   busy. Clear, append and mark each emit one result beat, registered in the
//   output register after the command leaves the queue. Nearest and count scan
//   the table once through a 4-stage distance pipe fed from the tile memories.
//   Evict rescans once per evicted tile plus one final pass.
// Reset:
//   Synchronous, active high. Empties the table and queue, tile edge = 1024.
//   Tile memories are not cleared; only entries below the tile count are read.
// Backpressure:
//   A stalled response holds; the engine waits, then the queue fills and
//   req_stall rises.
`timescale 1ns / 1ps
`default_nettype none
module nearest_pending_tile_selector_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire npts_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output npts_pkg::rsp_type      rsp_data,
   input  wire logic              csr_wr_en,
   input  wire logic [15:0]       csr_wr_data
);
   import npts_pkg::*;

   logic    cmd_valid, cmd_pop;
   cmd_type cmd_data;

   npts_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd_valid   (cmd_valid),
      .cmd_data    (cmd_data),
      .cmd_pop     (cmd_pop)
   );

   // engine: tables, scan pipe and output register
   npts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );
endmodule
`default_nettype wire

// ===== hdl/npts_checker.sv =====
// Port-level checks for the tile selector, bound to the top level.
// Depends on npts_pkg and nearest_pending_tile_selector_unit.
`timescale 1ns / 1ps
`default_nettype none
module npts_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire npts_pkg::rsp_type rsp_data
);
   import npts_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid && !req_stall)
      else $error("response or stall right after reset");

   a_fail_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != StOk |->
         rsp_data.last && rsp_data.distance_squared == '0)
      else $error("failed result not final or carries distance");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.full_tiles <= 7'(MaxTiles) && rsp_data.status <= StIgnored)
      else $error("bad count or status");
endmodule

bind nearest_pending_tile_selector_unit npts_checker u_npts_checker (.*);
`default_nettype wire
